>>> src/tcg_pkg.sv
// Shared types, constants and tables for the text cell glyph pixel renderer.
package tcg_pkg;

   localparam int GLYPH_WIDTH = 8;
   localparam int CHAR_W      = 8;
   localparam int ROW_W       = 4;
   localparam int STORE_AW    = CHAR_W + ROW_W;
   localparam int STORE_DEPTH = 1 << STORE_AW;
   localparam int ATTR_W      = 8;
   localparam int COLUMN_W    = 8;
   localparam int LINE_W      = 7;
   localparam int OFFSET_W    = 26;
   localparam int PIXEL_W     = 32;
   localparam int COUNT_W     = 3;
   localparam int PITCH_W     = 14;
   localparam int CBITS_W     = 4;
   localparam int CSHIFT_W    = 5;
   localparam int DEPTH_W     = 2;
   localparam int CHAN_W      = 8;
   localparam int CHAN_V_W    = 15;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 14;

   typedef enum logic [0:0] {
      OP_STORE  = 1'b0,
      OP_RENDER = 1'b1
   } opcode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RED_BITS    = 3'd0,
      CSR_RED_SHIFT   = 3'd1,
      CSR_GREEN_BITS  = 3'd2,
      CSR_GREEN_SHIFT = 3'd3,
      CSR_BLUE_BITS   = 3'd4,
      CSR_BLUE_SHIFT  = 3'd5,
      CSR_PIXEL_DEPTH = 3'd6,
      CSR_LINE_PITCH  = 3'd7
   } csr_index_type;

   typedef enum logic [DEPTH_W-1:0] {
      DEPTH_2B = 2'd0,
      DEPTH_3B = 2'd1,
      DEPTH_4B = 2'd2
   } depth_type;

   typedef struct packed {
      logic [CBITS_W-1:0]  red_bits;
      logic [CSHIFT_W-1:0] red_shift;
      logic [CBITS_W-1:0]  green_bits;
      logic [CSHIFT_W-1:0] green_shift;
      logic [CBITS_W-1:0]  blue_bits;
      logic [CSHIFT_W-1:0] blue_shift;
      depth_type           pixel_depth;
      logic [PITCH_W-1:0]  line_pitch;
   } cfg_type;

   typedef struct packed {
      logic [CHAN_W-1:0] r;
      logic [CHAN_W-1:0] g;
      logic [CHAN_W-1:0] b;
   } rgb_type;

   typedef struct packed {
      logic [GLYPH_WIDTH-1:0] glyph;
      logic [ATTR_W-1:0]      attribute;
   } fetch_type;

   typedef struct packed {
      logic [OFFSET_W-1:0]    offset;
      logic [PIXEL_W-1:0]     fg;
      logic [PIXEL_W-1:0]     bg;
      logic [COUNT_W-1:0]     bytes;
      logic [GLYPH_WIDTH-1:0] glyph;
   } row_type;

   typedef struct packed {
      logic [OFFSET_W-1:0] byte_offset;
      logic [PIXEL_W-1:0]  pixel_value;
      logic [COUNT_W-1:0]  byte_count;
      logic                last_pixel;
   } pixel_type;

   function automatic int row_idx_width(input int cell_height);
      return $clog2(((1 << LINE_W) - 1) * cell_height + (1 << ROW_W));
   endfunction

   function automatic int col_px_width(input int cell_width);
      return $clog2(((1 << COLUMN_W) - 1) * cell_width + 1);
   endfunction

   function automatic rgb_type palette_rgb(input logic [3:0] idx);
      rgb_type c;
      case (idx)
         4'd0:    c = '{8'd0,   8'd0,   8'd0};
         4'd1:    c = '{8'd0,   8'd0,   8'd128};
         4'd2:    c = '{8'd0,   8'd128, 8'd0};
         4'd3:    c = '{8'd0,   8'd128, 8'd128};
         4'd4:    c = '{8'd128, 8'd0,   8'd0};
         4'd5:    c = '{8'd128, 8'd0,   8'd128};
         4'd6:    c = '{8'd128, 8'd128, 8'd0};
         4'd7:    c = '{8'd168, 8'd168, 8'd168};
         4'd8:    c = '{8'd128, 8'd128, 8'd128};
         4'd9:    c = '{8'd0,   8'd0,   8'd255};
         4'd10:   c = '{8'd0,   8'd255, 8'd0};
         4'd11:   c = '{8'd0,   8'd255, 8'd255};
         4'd12:   c = '{8'd255, 8'd0,   8'd0};
         4'd13:   c = '{8'd255, 8'd0,   8'd255};
         4'd14:   c = '{8'd255, 8'd255, 8'd0};
         default: c = '{8'd255, 8'd255, 8'd255};
      endcase
      return c;
   endfunction

   function automatic logic [COUNT_W-1:0] pixel_bytes(input depth_type d);
      logic [COUNT_W-1:0] n;
      case (d)
         DEPTH_2B: n = 3'd2;
         DEPTH_3B: n = 3'd3;
         default:  n = 3'd4;
      endcase
      return n;
   endfunction

   function automatic logic [PIXEL_W-1:0] pixel_mask(input logic [COUNT_W-1:0] n);
      logic [PIXEL_W-1:0] m;
      case (n)
         3'd2:    m = 32'h0000_ffff;
         3'd3:    m = 32'h00ff_ffff;
         default: m = 32'hffff_ffff;
      endcase
      return m;
   endfunction

endpackage

>>> src/tcg_ifs.sv
// Valid/ready channel interfaces for request, response and register words.
interface tcg_req_if;
   logic                              valid;
   logic                              ready;
   tcg_pkg::opcode_type               opcode;
   logic [tcg_pkg::CHAR_W-1:0]        char_code;
   logic [tcg_pkg::ROW_W-1:0]         row_in_cell;
   logic [tcg_pkg::GLYPH_WIDTH-1:0]   glyph_bits;
   logic [tcg_pkg::ATTR_W-1:0]        attribute;
   logic [tcg_pkg::COLUMN_W-1:0]      cell_column;
   logic [tcg_pkg::LINE_W-1:0]        cell_line;

   modport source (
      output valid, opcode, char_code, row_in_cell, glyph_bits, attribute,
             cell_column, cell_line,
      input  ready
   );
   modport sink (
      input  valid, opcode, char_code, row_in_cell, glyph_bits, attribute,
             cell_column, cell_line,
      output ready
   );
endinterface

interface tcg_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [tcg_pkg::OFFSET_W-1:0]  byte_offset;
   logic [tcg_pkg::PIXEL_W-1:0]   pixel_value;
   logic [tcg_pkg::COUNT_W-1:0]   byte_count;
   logic                          last_pixel;

   modport source (
      output valid, byte_offset, pixel_value, byte_count, last_pixel,
      input  ready
   );
   modport sink (
      input  valid, byte_offset, pixel_value, byte_count, last_pixel,
      output ready
   );
endinterface

interface tcg_csr_if;
   logic                            valid;
   logic                            ready;
   tcg_pkg::csr_index_type          index;
   logic [tcg_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> src/tcg_csr.sv
// Configuration register file for pixel format and line pitch.
module tcg_csr (
   input  logic             clock,
   input  logic             reset,
   tcg_csr_if.sink          csr,
   output tcg_pkg::cfg_type cfg
);
   import tcg_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr.ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         unique case (csr.index)
            CSR_RED_BITS:    cfg_in.red_bits    = csr.data[CBITS_W-1:0];
            CSR_RED_SHIFT:   cfg_in.red_shift   = csr.data[CSHIFT_W-1:0];
            CSR_GREEN_BITS:  cfg_in.green_bits  = csr.data[CBITS_W-1:0];
            CSR_GREEN_SHIFT: cfg_in.green_shift = csr.data[CSHIFT_W-1:0];
            CSR_BLUE_BITS:   cfg_in.blue_bits   = csr.data[CBITS_W-1:0];
            CSR_BLUE_SHIFT:  cfg_in.blue_shift  = csr.data[CSHIFT_W-1:0];
            CSR_PIXEL_DEPTH: cfg_in.pixel_depth = depth_type'(csr.data[DEPTH_W-1:0]);
            CSR_LINE_PITCH:  cfg_in.line_pitch  = csr.data[PITCH_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.red_bits    <= 4'd8;
         cfg_ff.red_shift   <= 5'd16;
         cfg_ff.green_bits  <= 4'd8;
         cfg_ff.green_shift <= 5'd8;
         cfg_ff.blue_bits   <= 4'd8;
         cfg_ff.blue_shift  <= 5'd0;
         cfg_ff.pixel_depth <= DEPTH_4B;
         cfg_ff.line_pitch  <= 14'd4096;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> src/tcg_fetch.sv
// Request intake stage: glyph store write and read, cell position scaling.
module tcg_fetch #(
   parameter int CELL_WIDTH   = 9,
   parameter int CELL_HEIGHT  = 16,
   parameter int GLYPH_HEIGHT = 16,
   parameter int ROW_IDX_W    = 12,
   parameter int COL_PX_W     = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   tcg_req_if.sink                req,
   output logic                   s1_valid,
   output tcg_pkg::fetch_type     s1,
   output logic [ROW_IDX_W-1:0]   s1_row_idx,
   output logic [COL_PX_W-1:0]    s1_col_px,
   input  logic                   s1_take
);
   import tcg_pkg::*;

   logic [GLYPH_WIDTH-1:0] glyph_mem [STORE_DEPTH];

   logic                   accept;
   logic [STORE_AW-1:0]    addr;
   logic                   s1_valid_ff;
   logic                   s1_valid_in;
   logic [GLYPH_WIDTH-1:0] glyph_rd_ff;
   logic                   row_vis_ff;
   logic                   row_vis_in;
   logic [ATTR_W-1:0]      attr_ff;
   logic [ROW_IDX_W-1:0]   row_idx_ff;
   logic [ROW_IDX_W-1:0]   row_idx_in;
   logic [COL_PX_W-1:0]    col_px_ff;
   logic [COL_PX_W-1:0]    col_px_in;

   assign req.ready = !s1_valid_ff || s1_take;
   assign accept    = req.valid && req.ready;
   assign addr      = {req.char_code, req.row_in_cell};

   assign row_vis_in = 32'(req.row_in_cell) < GLYPH_HEIGHT;
   assign row_idx_in = ROW_IDX_W'(32'(req.cell_line) * CELL_HEIGHT + 32'(req.row_in_cell));
   assign col_px_in  = COL_PX_W'(32'(req.cell_column) * CELL_WIDTH);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = (req.opcode == OP_RENDER);
      end else if (s1_take) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req.opcode == OP_STORE) begin
         glyph_mem[addr] <= req.glyph_bits;
      end
      if (accept) begin
         glyph_rd_ff <= glyph_mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         row_vis_ff <= row_vis_in;
         attr_ff    <= req.attribute;
         row_idx_ff <= row_idx_in;
         col_px_ff  <= col_px_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   assign s1_valid     = s1_valid_ff;
   assign s1.glyph     = row_vis_ff ? glyph_rd_ff : '0;
   assign s1.attribute = attr_ff;
   assign s1_row_idx   = row_idx_ff;
   assign s1_col_px    = col_px_ff;

endmodule

>>> src/tcg_compute.sv
// Offset products, colour scaling and channel packing over two stages.
module tcg_compute #(
   parameter int ROW_IDX_W = 12,
   parameter int COL_PX_W  = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  tcg_pkg::cfg_type      cfg,
   input  logic                  s1_valid,
   input  tcg_pkg::fetch_type    s1,
   input  logic [ROW_IDX_W-1:0]  s1_row_idx,
   input  logic [COL_PX_W-1:0]   s1_col_px,
   output logic                  s1_take,
   output logic                  s3_valid,
   output tcg_pkg::row_type      s3,
   input  logic                  s3_ready
);
   import tcg_pkg::*;

   localparam int LPROD_W = PITCH_W + ROW_IDX_W;
   localparam int CPROD_W = COUNT_W + COL_PX_W;

   function automatic logic [CHAN_V_W-1:0] scale_channel(
      input logic [CHAN_W-1:0]  c,
      input logic [CBITS_W-1:0] nbits
   );
      logic [CHAN_W+CHAN_V_W-1:0] wide;
      wide = (CHAN_W + CHAN_V_W)'(c) << nbits;
      return wide[CHAN_W+CHAN_V_W-1:CHAN_W];
   endfunction

   function automatic logic [PIXEL_W-1:0] place_channel(
      input logic [CHAN_V_W-1:0] v,
      input logic [CSHIFT_W-1:0] sh
   );
      return PIXEL_W'(v) << sh;
   endfunction

   rgb_type              fg_rgb;
   rgb_type              bg_rgb;
   logic [CHAN_W-1:0]    fg_c [3];
   logic [CHAN_W-1:0]    bg_c [3];
   logic [CBITS_W-1:0]   ch_bits [3];
   logic [CSHIFT_W-1:0]  ch_shift [3];
   logic [LPROD_W-1:0]   line_prod;
   logic [CPROD_W-1:0]   col_prod;
   logic [COUNT_W-1:0]   bytes_in;

   logic                   s2_valid_ff;
   logic                   s2_valid_in;
   logic                   s2_take;
   logic [OFFSET_W-1:0]    s2_line_ff;
   logic [CPROD_W-1:0]     s2_col_ff;
   logic [CHAN_V_W-1:0]    s2_fg_v_ff [3];
   logic [CHAN_V_W-1:0]    s2_bg_v_ff [3];
   logic [CHAN_V_W-1:0]    s2_fg_v_in [3];
   logic [CHAN_V_W-1:0]    s2_bg_v_in [3];
   logic [COUNT_W-1:0]     s2_bytes_ff;
   logic [GLYPH_WIDTH-1:0] s2_glyph_ff;

   logic                 s3_valid_ff;
   logic                 s3_valid_in;
   logic                 s3_take;
   row_type              s3_ff;
   row_type              s3_in;
   logic [PIXEL_W-1:0]   mask;
   logic [PIXEL_W-1:0]   fg_pack;
   logic [PIXEL_W-1:0]   bg_pack;

   assign s3_take  = s3_valid_ff && s3_ready;
   assign s2_take  = s2_valid_ff && (!s3_valid_ff || s3_take);
   assign s1_take  = s1_valid && (!s2_valid_ff || s2_take);

   // stage 2: products and channel scaling
   assign fg_rgb   = palette_rgb(s1.attribute[3:0]);
   assign bg_rgb   = palette_rgb(s1.attribute[7:4]);
   assign bytes_in = pixel_bytes(cfg.pixel_depth);

   always_comb begin
      fg_c[0]     = fg_rgb.r;
      fg_c[1]     = fg_rgb.g;
      fg_c[2]     = fg_rgb.b;
      bg_c[0]     = bg_rgb.r;
      bg_c[1]     = bg_rgb.g;
      bg_c[2]     = bg_rgb.b;
      ch_bits[0]  = cfg.red_bits;
      ch_bits[1]  = cfg.green_bits;
      ch_bits[2]  = cfg.blue_bits;
      ch_shift[0] = cfg.red_shift;
      ch_shift[1] = cfg.green_shift;
      ch_shift[2] = cfg.blue_shift;
      for (int i = 0; i < 3; i++) begin
         s2_fg_v_in[i] = scale_channel(fg_c[i], ch_bits[i]);
         s2_bg_v_in[i] = scale_channel(bg_c[i], ch_bits[i]);
      end
   end

   assign line_prod = LPROD_W'(cfg.line_pitch) * LPROD_W'(s1_row_idx);
   assign col_prod  = CPROD_W'(bytes_in) * CPROD_W'(s1_col_px);

   always_comb begin
      s2_valid_in = s2_valid_ff;
      if (s1_take) begin
         s2_valid_in = 1'b1;
      end else if (s2_take) begin
         s2_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_take) begin
         s2_line_ff  <= OFFSET_W'(line_prod);
         s2_col_ff   <= col_prod;
         s2_bytes_ff <= bytes_in;
         s2_glyph_ff <= s1.glyph;
         for (int i = 0; i < 3; i++) begin
            s2_fg_v_ff[i] <= s2_fg_v_in[i];
            s2_bg_v_ff[i] <= s2_bg_v_in[i];
         end
      end
   end

   // stage 3: base offset and packed colours
   assign mask    = pixel_mask(s2_bytes_ff);
   assign fg_pack = place_channel(s2_fg_v_ff[0], ch_shift[0])
                  | place_channel(s2_fg_v_ff[1], ch_shift[1])
                  | place_channel(s2_fg_v_ff[2], ch_shift[2]);
   assign bg_pack = place_channel(s2_bg_v_ff[0], ch_shift[0])
                  | place_channel(s2_bg_v_ff[1], ch_shift[1])
                  | place_channel(s2_bg_v_ff[2], ch_shift[2]);

   always_comb begin
      s3_in.offset = OFFSET_W'(s2_line_ff + OFFSET_W'(s2_col_ff));
      s3_in.fg     = fg_pack & mask;
      s3_in.bg     = bg_pack & mask;
      s3_in.bytes  = s2_bytes_ff;
      s3_in.glyph  = s2_glyph_ff;
   end

   always_comb begin
      s3_valid_in = s3_valid_ff;
      if (s2_take) begin
         s3_valid_in = 1'b1;
      end else if (s3_take) begin
         s3_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_take) begin
         s3_ff <= s3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   assign s3_valid = s3_valid_ff;
   assign s3       = s3_ff;

endmodule

>>> src/tcg_serializer.sv
// Cell row to pixel serializer with registered response output.
module tcg_serializer #(
   parameter int CELL_WIDTH = 9
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             s3_valid,
   input  tcg_pkg::row_type s3,
   output logic             s3_ready,
   tcg_rsp_if.source        rsp
);
   import tcg_pkg::*;

   localparam int X_W = $clog2(CELL_WIDTH);
   localparam logic [X_W-1:0] LAST_X = X_W'(CELL_WIDTH - 1);

   logic            rec_valid_ff;
   logic            rec_valid_in;
   row_type         rec_ff;
   logic [X_W-1:0]  x_ff;
   logic [X_W-1:0]  x_in;
   logic            out_valid_ff;
   logic            out_valid_in;
   pixel_type       out_ff;
   pixel_type       out_in;
   logic            load_pix;
   logic            done;
   logic            s3_take;

   assign load_pix = rec_valid_ff && (!out_valid_ff || rsp.ready);
   assign done     = load_pix && (x_ff == LAST_X);
   assign s3_ready = !rec_valid_ff || done;
   assign s3_take  = s3_valid && s3_ready;

   always_comb begin
      rec_valid_in = rec_valid_ff;
      x_in         = x_ff;
      if (s3_take) begin
         rec_valid_in = 1'b1;
         x_in         = '0;
      end else if (done) begin
         rec_valid_in = 1'b0;
         x_in         = '0;
      end else if (load_pix) begin
         x_in = X_W'(x_ff + 1'b1);
      end
   end

   always_comb begin
      out_in.byte_offset = rec_ff.offset;
      out_in.pixel_value = rec_ff.glyph[GLYPH_WIDTH-1] ? rec_ff.fg : rec_ff.bg;
      out_in.byte_count  = rec_ff.bytes;
      out_in.last_pixel  = (x_ff == LAST_X);
      out_valid_in       = out_valid_ff;
      if (load_pix) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   // advance offset and glyph bits per emitted pixel
   always_ff @(posedge clock) begin
      if (s3_take) begin
         rec_ff <= s3;
      end else if (load_pix) begin
         rec_ff.offset <= OFFSET_W'(rec_ff.offset + OFFSET_W'(rec_ff.bytes));
         rec_ff.glyph  <= rec_ff.glyph << 1;
      end
      if (load_pix) begin
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_valid_ff <= 1'b0;
         x_ff         <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         rec_valid_ff <= rec_valid_in;
         x_ff         <= x_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.byte_offset = out_ff.byte_offset;
   assign rsp.pixel_value = out_ff.pixel_value;
   assign rsp.byte_count  = out_ff.byte_count;
   assign rsp.last_pixel  = out_ff.last_pixel;

   a_x_range: assert property (@(posedge clock) disable iff (reset)
      rec_valid_ff |-> x_ff <= LAST_X)
      else $error("pixel column past cell width");

   a_idle_x: assert property (@(posedge clock) disable iff (reset)
      !rec_valid_ff |-> x_ff == '0)
      else $error("pixel column not rewound with no row held");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      (load_pix && x_ff == LAST_X) |=> (out_valid_ff && out_ff.last_pixel))
      else $error("final pixel of row lacks last flag");

endmodule

>>> src/text_cell_glyph_pixel_renderer.sv
// Top level of the text cell glyph pixel renderer.
//
// Channels: req words either store one glyph row (opcode store) or render
// one scan row of a character cell (opcode render). rsp words carry one pixel
// each: framebuffer byte offset, device colour, byte count and a last flag.
// csr words write the pixel format and line pitch registers; write them only
// while no render is in flight.
// Path: a render request passes the fetch, stage 2, stage 3, serializer row
// and output registers before its first pixel is presented; the rest follow
// one per cycle while rsp.ready stays high. Throughput: a render yields
// CELL_WIDTH pixel words at the response port, which takes one pixel per
// cycle while rsp.ready is high; the next request is taken while the current
// row is still being emitted. A store gives no response.
// Reset: registers return to 32 bpp, 8:8:8 at 16/8/0, pitch 4096; the glyph
// store is not cleared and holds garbage until written.
// Stall: when rsp.ready is low the pixel word holds and the pipeline fills,
// then req.ready drops; nothing is lost or repeated.
module text_cell_glyph_pixel_renderer #(
   parameter int CELL_WIDTH   = 9,
   parameter int CELL_HEIGHT  = 16,
   parameter int GLYPH_HEIGHT = 16
) (
   input  logic       clock,
   input  logic       reset,
   tcg_req_if.sink    req_port,
   tcg_rsp_if.source  rsp_port,
   tcg_csr_if.sink    csr_port
);
   import tcg_pkg::*;

   localparam int ROW_IDX_W = row_idx_width(CELL_HEIGHT);
   localparam int COL_PX_W  = col_px_width(CELL_WIDTH);

   cfg_type               cfg;
   logic                  s1_valid;
   fetch_type             s1;
   logic [ROW_IDX_W-1:0]  s1_row_idx;
   logic [COL_PX_W-1:0]   s1_col_px;
   logic                  s1_take;
   logic                  s3_valid;
   row_type               s3;
   logic                  s3_ready;

   tcg_csr u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr_port),
      .cfg   (cfg)
   );

   tcg_fetch #(
      .CELL_WIDTH   (CELL_WIDTH),
      .CELL_HEIGHT  (CELL_HEIGHT),
      .GLYPH_HEIGHT (GLYPH_HEIGHT),
      .ROW_IDX_W    (ROW_IDX_W),
      .COL_PX_W     (COL_PX_W)
   ) u_fetch (
      .clock      (clock),
      .reset      (reset),
      .req        (req_port),
      .s1_valid   (s1_valid),
      .s1         (s1),
      .s1_row_idx (s1_row_idx),
      .s1_col_px  (s1_col_px),
      .s1_take    (s1_take)
   );

   tcg_compute #(
      .ROW_IDX_W (ROW_IDX_W),
      .COL_PX_W  (COL_PX_W)
   ) u_compute (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .s1_valid   (s1_valid),
      .s1         (s1),
      .s1_row_idx (s1_row_idx),
      .s1_col_px  (s1_col_px),
      .s1_take    (s1_take),
      .s3_valid   (s3_valid),
      .s3         (s3),
      .s3_ready   (s3_ready)
   );

   tcg_serializer #(
      .CELL_WIDTH (CELL_WIDTH)
   ) u_serializer (
      .clock    (clock),
      .reset    (reset),
      .s3_valid (s3_valid),
      .s3       (s3),
      .s3_ready (s3_ready),
      .rsp      (rsp_port)
   );

endmodule
